// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, clocked on clk, held off during reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/bphs_pkg.sv -----
package bphs_pkg;

    localparam int BinW      = 9;
    localparam int BinsN     = 512;
    localparam int AddrW     = 18;
    localparam int MemDepth  = 262144;
    localparam int CountW    = 32;
    localparam int VelW      = 24;
    localparam int CordicN   = 24;
    localparam int StepW     = 5;
    localparam int AccW      = 56;
    localparam int ZW        = 32;

    localparam logic [1:0] CMD_RECORD  = 2'd0;
    localparam logic [1:0] CMD_RD_PROF = 2'd1;
    localparam logic [1:0] CMD_RD_EX   = 2'd2;
    localparam logic [1:0] CMD_RD_EY   = 2'd3;

    localparam logic [0:0] REG_SCALE_X = 1'b0;
    localparam logic [0:0] REG_SCALE_Y = 1'b1;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [23:0]     pos_x;
        logic [23:0]     pos_y;
        logic [23:0]     vel_x;
        logic [23:0]     vel_y;
        logic [23:0]     vel_z;
        logic [BinW-1:0] read_row;
        logic [BinW-1:0] read_col;
    } item_t;

    typedef struct packed {
        logic [31:0] bin_count;
        logic        profile_hit;
        logic        emit_x_hit;
        logic        emit_y_hit;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item, start position and angle work
        logic cordic;    // one CORDIC step on both angle units
        logic finish;    // round angles, form addresses
        logic mem_read;  // issue reads on all three memories
        logic mem_write; // write back incremented counts, form result
        logic clear;     // clearing sweep write
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cordic_last;
        logic clear_last;
    } dp_stat_t;

    function automatic logic [ZW-1:0] atan_entry(input logic [StepW-1:0] i);
        logic [ZW-1:0] r;
        case (i)
            5'd0:  r = 32'd294912000;
            5'd1:  r = 32'd174096719;
            5'd2:  r = 32'd91987925;
            5'd3:  r = 32'd46694507;
            5'd4:  r = 32'd23437865;
            5'd5:  r = 32'd11730358;
            5'd6:  r = 32'd5866610;
            5'd7:  r = 32'd2933484;
            5'd8:  r = 32'd1466764;
            5'd9:  r = 32'd733385;
            5'd10: r = 32'd366693;
            5'd11: r = 32'd183346;
            5'd12: r = 32'd91673;
            5'd13: r = 32'd45837;
            5'd14: r = 32'd22918;
            5'd15: r = 32'd11459;
            5'd16: r = 32'd5730;
            5'd17: r = 32'd2865;
            5'd18: r = 32'd1432;
            5'd19: r = 32'd716;
            5'd20: r = 32'd358;
            5'd21: r = 32'd179;
            5'd22: r = 32'd90;
            5'd23: r = 32'd45;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/bphs_stream_if.sv -----
interface bphs_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/beam_phase_space_histogrammer.sv -----
// Channel | Dir | Payload
// in_s    | in  | cmd, pos_x/y, vel_x/y/z, read_row, read_col
// out_s   | out | bin_count, profile_hit, emit_x_hit, emit_y_hit
// A transaction steps through these states: accept in idle, 24 CORDIC
// steps (one per cycle, x-theta and y-phi units side by side), finish, memory
// read, write back and output. A stall on out_s holds it in the output state.
// After reset all 262144 addresses of the three count memories are cleared,
// one address a cycle; no transaction is accepted until the sweep ends.
// The result register holds while out_s stalls; the next item waits.
`include "assert_macros.svh"
module beam_phase_space_histogrammer
    import bphs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bphs_stream_if.sink   in_s,
    bphs_stream_if.source out_s,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    logic [9:0] scale_x_reg, scale_y_reg;
    dp_cmd_t    dcmd;
    dp_stat_t   dstat;
    result_t    res;
    logic       any_hit;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg <= 10'd100;
            scale_y_reg <= 10'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE_X: scale_x_reg <= cfg_data;
                REG_SCALE_Y: scale_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    bphs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_s.valid),
        .in_ready  (in_s.ready),
        .out_valid (out_s.valid),
        .out_ready (out_s.ready),
        .stat      (dstat),
        .cmd       (dcmd)
    );

    bphs_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (dcmd),
        .stat    (dstat),
        .item    (in_s.data),
        .scale_x (scale_x_reg),
        .scale_y (scale_y_reg),
        .result  (res)
    );

    assign out_s.data = res;
    assign any_hit    = res.profile_hit | res.emit_x_hit | res.emit_y_hit;

    // a hit only comes from a record, which returns no count
    `ASSERT_IMPL(a_read_no_hit, out_s.valid && any_hit, res.bin_count == '0)
    // no input taken while a result is waiting
    `ASSERT_IMPL(a_no_overlap, out_s.valid, !in_s.ready)
    // load is followed by CORDIC work
    `ASSERT_NEXT(a_load_cordic, dcmd.load, dcmd.cordic)

endmodule

// ----- rtl/bphs_ctrl.sv -----
module bphs_ctrl
    import bphs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_CORDIC = 7'b0000100,
        ST_FINISH = 7'b0001000,
        ST_READ   = 7'b0010000,
        ST_WRITE  = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                cmd.cordic = 1'b1;
                if (stat.cordic_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.mem_write = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/bphs_datapath.sv -----
module bphs_datapath
    import bphs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  item_t       item,
    input  logic [9:0]  scale_x,
    input  logic [9:0]  scale_y,
    output result_t     result
);

    logic [AddrW-1:0] clr_reg;
    logic [StepW-1:0] step_reg;

    item_t            it_reg;
    logic signed [34:0] px_prod_reg, py_prod_reg;
    logic signed [AccW-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic signed [ZW:0] za_reg, zb_reg;
    logic             skip_a_reg, skip_b_reg;

    logic [AddrW-1:0] pa_reg, ea_reg, eb_reg;
    logic             okp_reg, oka_reg, okb_reg;
    logic [CountW-1:0] prof_q_reg, ex_q_reg, ey_q_reg;

    logic [CountW-1:0] prof_mem [MemDepth];
    logic [CountW-1:0] ex_mem   [MemDepth];
    logic [CountW-1:0] ey_mem   [MemDepth];

    assign stat.clear_last  = (clr_reg == AddrW'(MemDepth - 1));
    assign stat.cordic_last = (step_reg == StepW'(CordicN - 1));

    function automatic logic signed [AccW-1:0] vel_ext(input logic [VelW-1:0] v);
        return {{(AccW-VelW-30){v[VelW-1]}}, v, 30'd0};
    endfunction

    function automatic logic signed [AccW-1:0] absv_ext(input logic [VelW-1:0] v);
        logic signed [VelW:0] s;
        s = $signed({v[VelW-1], v});
        if (s < 0)
            s = -s;
        return {{(AccW-VelW-31){1'b0}}, s, 30'd0};
    endfunction

    // round to nearest, halves away from zero, dropping 16 fraction bits
    function automatic logic signed [34:0] rnd16(input logic signed [34:0] v);
        logic signed [34:0] a;
        a = (v < 0) ? -v : v;
        a = (a + 35'sd32768) >>> 16;
        return (v < 0) ? -a : a;
    endfunction

    function automatic logic signed [ZW:0] rnd16z(input logic signed [ZW:0] v);
        logic signed [ZW:0] a;
        a = (v < 0) ? -v : v;
        a = (a + 33'sd32768) >>> 16;
        return (v < 0) ? -a : a;
    endfunction

    logic signed [34:0] bx, by;
    logic signed [ZW:0] ta, tb;
    logic signed [ZW:0] atn;
    always_comb
    begin
        bx  = rnd16(px_prod_reg) + 35'sd256;
        by  = rnd16(py_prod_reg) + 35'sd256;
        ta  = rnd16z(za_reg) + 33'sd256;
        tb  = rnd16z(zb_reg) + 33'sd256;
        atn = $signed({1'b0, atan_entry(step_reg)});
    end

    logic bx_ok, by_ok, ta_ok, tb_ok;
    assign bx_ok = (bx > 0) && (bx < 35'sd512);
    assign by_ok = (by > 0) && (by < 35'sd512);
    assign ta_ok = (ta > 0) && (ta < 33'sd512);
    assign tb_ok = (tb > 0) && (tb < 33'sd512);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.load)
                step_reg <= '0;
            else if (cmd.cordic)
                step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_reg      <= item;
            px_prod_reg <= 35'($signed(item.pos_x) * $signed({1'b0, scale_x}));
            py_prod_reg <= 35'($signed(item.pos_y) * $signed({1'b0, scale_y}));
            xa_reg      <= absv_ext(item.vel_z);
            xb_reg      <= absv_ext(item.vel_z);
            ya_reg      <= vel_ext(item.vel_x);
            yb_reg      <= vel_ext(item.vel_y);
            za_reg      <= '0;
            zb_reg      <= '0;
            skip_a_reg  <= (item.vel_x == '0) && (item.vel_z == '0);
            skip_b_reg  <= (item.vel_y == '0) && (item.vel_z == '0);
        end
        if (cmd.cordic)
        begin
            if (ya_reg >= 0)
            begin
                xa_reg <= xa_reg + (ya_reg >>> step_reg);
                ya_reg <= ya_reg - (xa_reg >>> step_reg);
                za_reg <= za_reg + atn;
            end
            else
            begin
                xa_reg <= xa_reg - (ya_reg >>> step_reg);
                ya_reg <= ya_reg + (xa_reg >>> step_reg);
                za_reg <= za_reg - atn;
            end
            if (yb_reg >= 0)
            begin
                xb_reg <= xb_reg + (yb_reg >>> step_reg);
                yb_reg <= yb_reg - (xb_reg >>> step_reg);
                zb_reg <= zb_reg + atn;
            end
            else
            begin
                xb_reg <= xb_reg - (yb_reg >>> step_reg);
                yb_reg <= yb_reg + (xb_reg >>> step_reg);
                zb_reg <= zb_reg - atn;
            end
        end
        if (cmd.finish)
        begin
            case (it_reg.cmd)
                CMD_RECORD:
                begin
                    pa_reg  <= {bx[BinW-1:0], by[BinW-1:0]};
                    ea_reg  <= {bx[BinW-1:0], ta[BinW-1:0]};
                    eb_reg  <= {by[BinW-1:0], tb[BinW-1:0]};
                    okp_reg <= bx_ok && by_ok;
                    oka_reg <= bx_ok && !skip_a_reg && ta_ok;
                    okb_reg <= by_ok && !skip_b_reg && tb_ok;
                end
                default:
                begin
                    pa_reg  <= {it_reg.read_row, it_reg.read_col};
                    ea_reg  <= {it_reg.read_row, it_reg.read_col};
                    eb_reg  <= {it_reg.read_row, it_reg.read_col};
                    okp_reg <= 1'b0;
                    oka_reg <= 1'b0;
                    okb_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.mem_write)
        begin
            result.profile_hit <= okp_reg;
            result.emit_x_hit  <= oka_reg;
            result.emit_y_hit  <= okb_reg;
            case (it_reg.cmd)
                CMD_RD_PROF: result.bin_count <= prof_q_reg;
                CMD_RD_EX:   result.bin_count <= ex_q_reg;
                CMD_RD_EY:   result.bin_count <= ey_q_reg;
                default:     result.bin_count <= '0;
            endcase
        end
    end

    // memories: one port each, read then write back
    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            prof_q_reg <= prof_mem[pa_reg];
            ex_q_reg   <= ex_mem[ea_reg];
            ey_q_reg   <= ey_mem[eb_reg];
        end
        if (cmd.clear)
        begin
            prof_mem[clr_reg] <= '0;
            ex_mem[clr_reg]   <= '0;
            ey_mem[clr_reg]   <= '0;
        end
        else if (cmd.mem_write)
        begin
            if (okp_reg && prof_q_reg != '1)
                prof_mem[pa_reg] <= prof_q_reg + 1'b1;
            if (oka_reg && ex_q_reg != '1)
                ex_mem[ea_reg] <= ex_q_reg + 1'b1;
            if (okb_reg && ey_q_reg != '1)
                ey_mem[eb_reg] <= ey_q_reg + 1'b1;
        end
    end

endmodule

// ----- tb/tb_beam_phase_space_histogrammer.sv -----
// Testbench for the beam phase-space histogrammer.
// Records and reads are pushed through in_s and predicted in step with the
// block: three sparse count maps, two scale registers and a bit-exact CORDIC
// for the angle bins. Each out_s transaction is checked field by field
// against the oldest waiting prediction.
module tb_beam_phase_space_histogrammer;
    import bphs_pkg::*;

    localparam int ItemW   = $bits(item_t);
    localparam int ResultW = $bits(result_t);
    localparam int HalfBin = BinsN / 2;
    localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [9:0] cfg_data;
    bit failed;

    bphs_stream_if #(.W(ItemW))   in_s ();
    bphs_stream_if #(.W(ResultW)) out_s ();

    beam_phase_space_histogrammer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_s      (in_s.sink),
        .out_s     (out_s.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Generous ceiling. It covers the clearing sweep of all 262144 addresses,
    // then about 1300 transactions, plus the longest gaps on both sides.
    initial
    begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Predicted state. The count maps are sparse: an entry not present
    // reads as zero.
    logic [9:0]  model_scale_x;
    logic [9:0]  model_scale_y;
    logic [31:0] prof_map [int];
    logic [31:0] emx_map  [int];
    logic [31:0] emy_map  [int];
    result_t     pending_q [$];

    // Arithmetic shift right that rounds towards minus infinity.
    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    // Rounds away from zero on halves, at a 2^16 scale.
    function automatic longint round_q16(input longint v);
        if (v >= 0)
            return (v + 32768) >>> 16;
        return -((-v + 32768) >>> 16);
    endfunction

    function automatic longint atan_table(input int i);
        longint t [24] = '{294912000, 174096719, 91987925, 46694507, 23437865,
                           11730358, 5866610, 2933484, 1466764, 733385, 366693,
                           183346, 91673, 45837, 22918, 11459, 5730, 2865,
                           1432, 716, 358, 179, 90, 45};
        return t[i];
    endfunction

    // atan2(num, |den|), in hundredths of a degree.
    function automatic longint angle_centideg(input longint num, input longint den);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = (den < 0 ? -den : den) <<< 30;
        y = num <<< 30;
        z = 0;
        for (int i = 0; i < CordicN; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_table(i);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_table(i);
            end
        end
        return round_q16(z);
    endfunction

    function automatic result_t predict_bin_update(input item_t it);
        result_t r;
        longint  px;
        longint  py;
        longint  ang;
        longint  vx;
        longint  vy;
        longint  vz;
        bit      okx;
        bit      oky;
        int      key;
        r  = '0;
        vx = longint'(signed'(it.vel_x));
        vy = longint'(signed'(it.vel_y));
        vz = longint'(signed'(it.vel_z));
        case (it.cmd)
            CMD_RECORD:
            begin
                px  = round_q16(longint'(signed'(it.pos_x)) * longint'(model_scale_x)) + HalfBin;
                py  = round_q16(longint'(signed'(it.pos_y)) * longint'(model_scale_y)) + HalfBin;
                okx = px > 0 && px < BinsN;
                oky = py > 0 && py < BinsN;
                if (okx && oky)
                begin
                    key = int'(px) * BinsN + int'(py);
                    if (!prof_map.exists(key))
                        prof_map[key] = '0;
                    if (prof_map[key] != CountMax)
                        prof_map[key]++;
                    r.profile_hit = 1'b1;
                end
                if (okx && !(vx == 0 && vz == 0))
                begin
                    ang = angle_centideg(vx, vz) + HalfBin;
                    if (ang > 0 && ang < BinsN)
                    begin
                        key = int'(px) * BinsN + int'(ang);
                        if (!emx_map.exists(key))
                            emx_map[key] = '0;
                        if (emx_map[key] != CountMax)
                            emx_map[key]++;
                        r.emit_x_hit = 1'b1;
                    end
                end
                if (oky && !(vy == 0 && vz == 0))
                begin
                    ang = angle_centideg(vy, vz) + HalfBin;
                    if (ang > 0 && ang < BinsN)
                    begin
                        key = int'(py) * BinsN + int'(ang);
                        if (!emy_map.exists(key))
                            emy_map[key] = '0;
                        if (emy_map[key] != CountMax)
                            emy_map[key]++;
                        r.emit_y_hit = 1'b1;
                    end
                end
            end
            CMD_RD_PROF:
            begin
                key = int'(it.read_row) * BinsN + int'(it.read_col);
                if (prof_map.exists(key))
                    r.bin_count = prof_map[key];
            end
            CMD_RD_EX:
            begin
                key = int'(it.read_row) * BinsN + int'(it.read_col);
                if (emx_map.exists(key))
                    r.bin_count = emx_map[key];
            end
            default:
            begin
                key = int'(it.read_row) * BinsN + int'(it.read_col);
                if (emy_map.exists(key))
                    r.bin_count = emy_map[key];
            end
        endcase
        return r;
    endfunction

    // Mostly short gaps, sometimes a long one, sometimes none for a stretch.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Sink side: random back-pressure; results are checked at the rising edge.
    int stall_left;
    initial
    begin
        out_s.ready = 1'b0;
        stall_left  = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_s.ready <= 1'b0;
            end
            else
            begin
                out_s.ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_s.valid && out_s.ready)
        begin
            got = result_t'(out_s.data);
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected transaction %h", $realtime, got);
                failed = 1'b1;
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.bin_count !== want.bin_count)
                begin
                    $display("%0t: bin_count exp %0d got %0d", $realtime,
                             want.bin_count, got.bin_count);
                    failed = 1'b1;
                end
                if (got.profile_hit !== want.profile_hit)
                begin
                    $display("%0t: profile_hit exp %b got %b", $realtime,
                             want.profile_hit, got.profile_hit);
                    failed = 1'b1;
                end
                if (got.emit_x_hit !== want.emit_x_hit)
                begin
                    $display("%0t: emit_x_hit exp %b got %b", $realtime,
                             want.emit_x_hit, got.emit_x_hit);
                    failed = 1'b1;
                end
                if (got.emit_y_hit !== want.emit_y_hit)
                begin
                    $display("%0t: emit_y_hit exp %b got %b", $realtime,
                             want.emit_y_hit, got.emit_y_hit);
                    failed = 1'b1;
                end
            end
        end
    end

    // Drives one transaction and updates the prediction when it is accepted.
    // valid is left high; the caller lowers it only for an idle gap.
    task automatic send_item(input item_t it);
        in_s.valid <= 1'b1;
        in_s.data  <= it;
        @(posedge clk);
        while (!in_s.ready)
            @(posedge clk);
        pending_q.push_back(predict_bin_update(it));
        @(negedge clk);
    endtask

    task automatic send_with_gap(input item_t it);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_s.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        send_item(it);
    endtask

    // Registers are written only with nothing in flight.
    task automatic drain_then_write(input logic [0:0] idx, input logic [9:0] val);
        in_s.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_SCALE_X)
            model_scale_x = val;
        else
            model_scale_y = val;
    endtask

    function automatic logic [23:0] rand24();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return 24'h800000;
        if (p == 1)
            return 24'h7FFFFF;
        if (p == 2)
            return 24'h0;
        if (p < 6)
            return 24'($urandom);
        return 24'($signed($urandom_range(0, 4000)) - 2000);
    endfunction

    // Positions near the centre so that they land inside the histograms.
    function automatic logic [23:0] rand_pos();
        if ($urandom_range(0, 9) == 0)
            return rand24();
        return 24'($signed($urandom_range(0, 300000)) - 150000);
    endfunction

    // Directions mostly along +/-z, so the angles fall inside the bins.
    function automatic item_t rand_record();
        item_t it;
        it       = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.cmd   = CMD_RECORD;
        it.pos_x = rand_pos();
        it.pos_y = rand_pos();
        if ($urandom_range(0, 9) < 7)
        begin
            it.vel_z = ($urandom_range(0, 1) ? 24'd1 : -24'sd1) * 24'($urandom_range(1000, 8000000));
            it.vel_x = 24'($signed($urandom_range(0, 80000)) - 40000);
            it.vel_y = 24'($signed($urandom_range(0, 80000)) - 40000);
        end
        else
        begin
            it.vel_x = rand24();
            it.vel_y = rand24();
            it.vel_z = rand24();
        end
        return it;
    endfunction

    // Reads mostly aim at bins that have been hit, from a small window.
    function automatic item_t rand_read();
        item_t it;
        it     = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.cmd = 2'($urandom_range(1, 3));
        if ($urandom_range(0, 3) != 0)
        begin
            it.read_row = 9'($urandom_range(HalfBin - 30, HalfBin + 30));
            it.read_col = 9'($urandom_range(HalfBin - 60, HalfBin + 60));
        end
        return it;
    endfunction

    // Directed rows: stimulus and, where obvious, the expected result.
    typedef struct {
        item_t   it;
        bit      known;
        result_t res;
    } dir_row_t;

    function automatic item_t mk(input logic [1:0] c, input logic [23:0] px,
                                 input logic [23:0] py, input logic [23:0] vx,
                                 input logic [23:0] vy, input logic [23:0] vz,
                                 input logic [8:0] r, input logic [8:0] cl);
        item_t it;
        it = '{cmd: c, pos_x: px, pos_y: py, vel_x: vx, vel_y: vy, vel_z: vz,
               read_row: r, read_col: cl};
        return it;
    endfunction

    dir_row_t dir_tab [$];

    initial
    begin
        item_t    it;
        dir_row_t row;
        int       n_rand;

        failed        = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SCALE_X;
        cfg_data      = '0;
        in_s.valid    = 1'b0;
        in_s.data     = '0;
        model_scale_x = 10'd100;
        model_scale_y = 10'd100;

        // After reset, reads of never-hit bins and a clean centre hit.
        dir_tab.push_back('{mk(CMD_RD_PROF, 0, 0, 0, 0, 0, 256, 256), 1, '0});
        dir_tab.push_back('{mk(CMD_RD_EX, 0, 0, 0, 0, 0, 511, 511), 1, '0});
        dir_tab.push_back('{mk(CMD_RD_EY, 0, 0, 0, 0, 0, 0, 0), 1, '0});
        // Centre particle straight along z: all three hit.
        dir_tab.push_back('{mk(CMD_RECORD, 0, 0, 0, 0, 24'd1000, 0, 0), 1,
                            '{bin_count: 0, profile_hit: 1, emit_x_hit: 1, emit_y_hit: 1}});
        dir_tab.push_back('{mk(CMD_RD_PROF, 0, 0, 0, 0, 0, 256, 256), 1,
                            '{bin_count: 1, profile_hit: 0, emit_x_hit: 0, emit_y_hit: 0}});
        // Zero direction: both emittance maps skipped.
        dir_tab.push_back('{mk(CMD_RECORD, 0, 0, 0, 0, 0, 0, 0), 1,
                            '{bin_count: 0, profile_hit: 1, emit_x_hit: 0, emit_y_hit: 0}});
        // Extreme positions: far outside, nothing counts.
        dir_tab.push_back('{mk(CMD_RECORD, 24'h7FFFFF, 24'h800000, 24'd5, 24'd5, 24'd5, 0, 0),
                            1, '0});
        dir_tab.push_back('{mk(CMD_RECORD, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
                               24'h800000, 0, 0), 1, '0});
        // Extreme velocities at the centre; large angles fall outside.
        dir_tab.push_back('{mk(CMD_RECORD, 0, 0, 24'h7FFFFF, 24'h800000, 24'd1, 0, 0), 0, '0});
        dir_tab.push_back('{mk(CMD_RECORD, 0, 0, 24'hFFFFFF, 24'd1, 24'h800000, 0, 0), 0, '0});
        // Low edge: positions landing on index 0 and on index -1; both are excluded.
        dir_tab.push_back('{mk(CMD_RECORD, -24'sd167772, -24'sd167772, 0, 0, 24'd9, 0, 0),
                            0, '0});
        dir_tab.push_back('{mk(CMD_RECORD, -24'sd168428, 0, 24'd3, 24'd3, 24'd900, 0, 0),
                            0, '0});
        // Reads of the edges and of the bins just hit.
        dir_tab.push_back('{mk(CMD_RD_PROF, 0, 0, 0, 0, 0, 0, 0), 1, '0});
        dir_tab.push_back('{mk(CMD_RD_PROF, 0, 0, 0, 0, 0, 1, 1), 0, '0});
        dir_tab.push_back('{mk(CMD_RD_EX, 0, 0, 0, 0, 0, 256, 256), 0, '0});
        dir_tab.push_back('{mk(CMD_RD_EY, 0, 0, 0, 0, 0, 256, 256), 0, '0});
        dir_tab.push_back('{mk(CMD_RD_EX, 0, 0, 0, 0, 0, 1, 256), 0, '0});
        dir_tab.push_back('{mk(CMD_RD_EY, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                               24'hFFFFFF, 511, 511), 1, '0});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
        begin
            row = dir_tab[i];
            // Typed-in results must agree with the prediction as well;
            // the predictor runs once, from send_item.
            send_with_gap(row.it);
            if (row.known && pending_q[$] !== row.res)
            begin
                $display("%0t: directed row %0d exp %h predicted %h", $realtime, i,
                         row.res, pending_q[$]);
                failed = 1'b1;
            end
        end

        // Phases through several scale settings, extremes included.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: drain_then_write(REG_SCALE_X, 10'd1);
                1: drain_then_write(REG_SCALE_Y, 10'd1023);
                2: drain_then_write(REG_SCALE_X, 10'd1023);
                3: drain_then_write(REG_SCALE_Y, 10'd1);
                4: drain_then_write(REG_SCALE_X, 10'($urandom_range(1, 1023)));
                default:
                begin
                    drain_then_write(REG_SCALE_X, 10'd100);
                    drain_then_write(REG_SCALE_Y, 10'($urandom_range(20, 300)));
                end
            endcase
            n_rand = (ph == 5) ? 300 : 200;
            for (int k = 0; k < n_rand; k++)
            begin
                if ($urandom_range(0, 9) < 6)
                    it = rand_record();
                else
                    it = rand_read();
                // Hold-off once per phase until everything is back.
                if (k == n_rand / 2)
                begin
                    in_s.valid <= 1'b0;
                    while (pending_q.size() != 0)
                        @(negedge clk);
                end
                send_with_gap(it);
            end
        end

        in_s.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (!failed)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bphs_pkg.sv
rtl/bphs_stream_if.sv
rtl/bphs_ctrl.sv
rtl/bphs_datapath.sv
rtl/beam_phase_space_histogrammer.sv
tb/tb_beam_phase_space_histogrammer.sv
